// File: sv/dirty_tile_display_refresh_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the dirty tile display refresh block
// Checks are compiled in unless SYNTH is set.
// ---------------------------------------------------------------------------
`ifndef DIRTY_TILE_DISPLAY_REFRESH_MACROS_SVH
`define DIRTY_TILE_DISPLAY_REFRESH_MACROS_SVH

`ifndef SYNTH
// check outside reset
`define DTDR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// check that also covers reset
`define DTDR_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define DTDR_ASSERT(lbl, prop, msg)
`define DTDR_ASSERT_RST(lbl, prop, msg)
`endif

`endif

// File: sv/dtdr_pkg.sv
// ---------------------------------------------------------------------------
// dtdr_pkg
// Geometry, codes, lookup tables and helpers for the tile refresh block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package dtdr_pkg;

    localparam int SCREEN_WIDTH  = 160;
    localparam int SCREEN_HEIGHT = 128;
    localparam int TILE_WIDTH    = 16;
    localparam int TILE_HEIGHT   = 16;

    localparam int TILES_X       = (SCREEN_WIDTH + TILE_WIDTH - 1) / TILE_WIDTH;
    localparam int TILES_Y       = (SCREEN_HEIGHT + TILE_HEIGHT - 1) / TILE_HEIGHT;
    localparam int TILE_COUNT    = TILES_X * TILES_Y;
    localparam int PAIRS_PER_ROW = (TILE_WIDTH + 1) / 2;
    localparam int PIXELS        = SCREEN_WIDTH * SCREEN_HEIGHT;

    localparam int ADDR_W = $clog2(PIXELS);
    localparam int TX_W   = (TILES_X > 1) ? $clog2(TILES_X) : 1;
    localparam int TY_W   = (TILES_Y > 1) ? $clog2(TILES_Y) : 1;
    localparam int TI_W   = (TILE_COUNT > 1) ? $clog2(TILE_COUNT) : 1;
    localparam int PC_W   = (PAIRS_PER_ROW > 1) ? $clog2(PAIRS_PER_ROW) : 1;
    localparam int PR_W   = (TILE_HEIGHT > 1) ? $clog2(TILE_HEIGHT) : 1;
    localparam int CO_W   = 10;   // pixel coordinates incl. tile overhang

    // input kinds
    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_CLEAR = 2'd1;
    localparam logic [1:0] KIND_FETCH = 2'd2;

    // panel command words
    localparam logic [8:0] CMD_CASET = 9'h02A;
    localparam logic [8:0] CMD_RASET = 9'h02B;
    localparam logic [8:0] CMD_RAMWR = 9'h02C;
    localparam logic [8:0] DATA_FLAG = 9'h100;

    // header word slots
    localparam logic [3:0] HDR_CASET  = 4'd0;
    localparam logic [3:0] HDR_X_LO   = 4'd2;
    localparam logic [3:0] HDR_X_HI   = 4'd4;
    localparam logic [3:0] HDR_RASET  = 4'd5;
    localparam logic [3:0] HDR_Y_LO   = 4'd7;
    localparam logic [3:0] HDR_Y_HI   = 4'd9;
    localparam logic [3:0] HDR_RAMWR  = 4'd10;

    // config register indexes
    localparam logic REG_COL_OFFSET = 1'b0;
    localparam logic REG_ROW_OFFSET = 1'b1;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] pos_x;
        logic [7:0] pos_y;
        logic [7:0] color;
    } t_item;

    typedef logic [TX_W-1:0] t_tcol_lut [256];
    typedef logic [TY_W-1:0] t_trow_lut [256];

    function automatic t_tcol_lut build_tcol();
        t_tcol_lut lut;
        for (int i = 0; i < 256; i++) begin
            lut[i] = TX_W'((i / TILE_WIDTH) % (1 << TX_W));
        end
        return lut;
    endfunction

    function automatic t_trow_lut build_trow();
        t_trow_lut lut;
        for (int i = 0; i < 256; i++) begin
            lut[i] = TY_W'((i / TILE_HEIGHT) % (1 << TY_W));
        end
        return lut;
    endfunction

    localparam t_tcol_lut TCOL_LUT = build_tcol();
    localparam t_trow_lut TROW_LUT = build_trow();

    function automatic logic [8:0] rev9(input logic [8:0] v);
        logic [8:0] r;
        for (int i = 0; i < 9; i++) begin
            r[8 - i] = v[i];
        end
        return r;
    endfunction

endpackage

// File: sv/dtdr_front.sv
// ---------------------------------------------------------------------------
// dtdr_front
// Input side: takes beats, drops unused kinds, queues two items.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module dtdr_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  dtdr_pkg::t_item i_item,
    output logic           o_q_valid,
    output dtdr_pkg::t_item o_q_item,
    input  logic           i_q_pop
);

    dtdr_pkg::t_item r_buf [2];
    logic            r_wp;
    logic            r_rp;
    logic [1:0]      r_cnt;
    logic            push;
    logic            accept;

    assign o_in_stall = (r_cnt == 2'd2);
    assign accept     = i_in_valid && !o_in_stall;
    // kind 3 is accepted but carries no work
    assign push       = accept && (i_item.kind == dtdr_pkg::KIND_WRITE ||
                                   i_item.kind == dtdr_pkg::KIND_CLEAR ||
                                   i_item.kind == dtdr_pkg::KIND_FETCH);
    assign o_q_valid  = (r_cnt != 2'd0);
    assign o_q_item   = r_buf[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_buf[r_wp] <= i_item;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (i_q_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, i_q_pop};
        end
    end

endmodule

// File: sv/dtdr_back.sv
// ---------------------------------------------------------------------------
// dtdr_back
// Work side: frame store, dirty flags, tile scan and word sequencer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "dirty_tile_display_refresh_macros.svh"

module dtdr_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_valid,
    input  dtdr_pkg::t_item i_q_item,
    output logic            o_q_pop,
    input  logic [7:0]      i_col_offset,
    input  logic [7:0]      i_row_offset,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output logic [8:0]      o_word,
    output logic            o_valid_res,
    output logic            o_last
);

    localparam int AW = dtdr_pkg::ADDR_W;
    localparam int XW = dtdr_pkg::TX_W;
    localparam int YW = dtdr_pkg::TY_W;
    localparam int IW = dtdr_pkg::TI_W;
    localparam int CW = dtdr_pkg::CO_W;
    localparam int PCW = dtdr_pkg::PC_W;
    localparam int PRW = dtdr_pkg::PR_W;

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_SCAN  = 6'b000100,
        S_RDP   = 6'b001000,
        S_RDQ   = 6'b010000,
        S_EMIT  = 6'b100000
    } t_state;

    t_state r_state;

    logic [7:0] r_mem [dtdr_pkg::PIXELS];
    logic [7:0] r_rdata;
    logic          mem_we;
    logic [AW-1:0] mem_wa;
    logic [7:0]    mem_wd;
    logic [AW-1:0] mem_ra;

    logic [AW-1:0] r_clr_addr;
    logic [7:0]    r_fill;
    logic [dtdr_pkg::TILE_COUNT-1:0] r_dirty;

    logic [IW-1:0] r_scan;
    logic [XW-1:0] r_scan_tx;
    logic [YW-1:0] r_scan_ty;
    logic [IW-1:0] r_probe;
    logic [XW-1:0] r_probe_tx;
    logic [YW-1:0] r_probe_ty;
    logic [IW-1:0] r_probe_n;
    logic [XW-1:0] r_act_tx;
    logic [YW-1:0] r_act_ty;

    logic          r_sending;
    logic          r_in_hdr;
    logic [3:0]    r_hdr;
    logic [1:0]    r_phase;
    logic [PCW-1:0] r_pcol;
    logic [PRW-1:0] r_prow;
    logic [7:0]    r_p;
    logic          r_none;

    logic          r_ov;
    logic [8:0]    r_word;
    logic          r_vres;
    logic          r_last;

    // next probe position, wrapping over the tile grid
    logic [IW-1:0] nx_idx;
    logic [XW-1:0] nx_tx;
    logic [YW-1:0] nx_ty;

    logic [CW-1:0] x0, y0, px, qx, py;
    logic          p_ok, q_ok;
    logic [AW-1:0] addr_p, addr_q;
    logic [7:0]    q_pix;
    logic [8:0]    word_c;
    logic          last_c;
    logic          load;
    logic          wr_ok;
    logic [IW-1:0] wr_tile;

    assign o_out_valid = r_ov;
    assign o_word      = r_word;
    assign o_valid_res = r_vres;
    assign o_last      = r_last;

    always_comb begin
        if (r_probe_tx == XW'(dtdr_pkg::TILES_X - 1)) begin
            nx_tx = '0;
            nx_ty = (r_probe_ty == YW'(dtdr_pkg::TILES_Y - 1)) ? '0 : r_probe_ty + 1'b1;
        end else begin
            nx_tx = r_probe_tx + 1'b1;
            nx_ty = r_probe_ty;
        end
        nx_idx = (r_probe == IW'(dtdr_pkg::TILE_COUNT - 1)) ? '0 : r_probe + 1'b1;
    end

    // pixel pair position in the active tile
    assign x0 = CW'(r_act_tx * dtdr_pkg::TILE_WIDTH);
    assign y0 = CW'(r_act_ty * dtdr_pkg::TILE_HEIGHT);
    assign px = x0 + CW'({r_pcol, 1'b0});
    assign qx = px + 1'b1;
    assign py = y0 + CW'(r_prow);
    assign p_ok = (px < dtdr_pkg::SCREEN_WIDTH) && (py < dtdr_pkg::SCREEN_HEIGHT);
    // right pixel of the pair may fall past the tile edge on odd widths
    assign q_ok = ((32'(r_pcol) * 2 + 1) < dtdr_pkg::TILE_WIDTH) &&
                  (qx < dtdr_pkg::SCREEN_WIDTH) && (py < dtdr_pkg::SCREEN_HEIGHT);
    assign addr_p = AW'(32'(py) * dtdr_pkg::SCREEN_WIDTH + 32'(px));
    assign addr_q = AW'(32'(py) * dtdr_pkg::SCREEN_WIDTH + 32'(qx));
    assign q_pix  = q_ok ? r_rdata : 8'd0;

    // write pixel decode
    assign wr_ok   = (i_q_item.pos_x < dtdr_pkg::SCREEN_WIDTH) &&
                     (i_q_item.pos_y < dtdr_pkg::SCREEN_HEIGHT);
    assign wr_tile = IW'(dtdr_pkg::TROW_LUT[i_q_item.pos_y] * dtdr_pkg::TILES_X +
                         dtdr_pkg::TCOL_LUT[i_q_item.pos_x]);

    always_comb begin
        logic [CW-1:0] hx_lo, hx_hi, hy_lo, hy_hi;
        hx_lo = x0 + CW'(i_col_offset);
        hx_hi = x0 + CW'(i_col_offset) + CW'(dtdr_pkg::TILE_WIDTH - 1);
        hy_lo = y0 + CW'(i_row_offset);
        hy_hi = y0 + CW'(i_row_offset) + CW'(dtdr_pkg::TILE_HEIGHT - 1);
        word_c = '0;
        if (r_none) begin
            word_c = '0;
        end else if (r_in_hdr) begin
            case (r_hdr)
                dtdr_pkg::HDR_CASET: word_c = dtdr_pkg::rev9(dtdr_pkg::CMD_CASET);
                dtdr_pkg::HDR_X_LO:  word_c = dtdr_pkg::rev9(dtdr_pkg::DATA_FLAG | {1'b0, hx_lo[7:0]});
                dtdr_pkg::HDR_X_HI:  word_c = dtdr_pkg::rev9(dtdr_pkg::DATA_FLAG | {1'b0, hx_hi[7:0]});
                dtdr_pkg::HDR_RASET: word_c = dtdr_pkg::rev9(dtdr_pkg::CMD_RASET);
                dtdr_pkg::HDR_Y_LO:  word_c = dtdr_pkg::rev9(dtdr_pkg::DATA_FLAG | {1'b0, hy_lo[7:0]});
                dtdr_pkg::HDR_Y_HI:  word_c = dtdr_pkg::rev9(dtdr_pkg::DATA_FLAG | {1'b0, hy_hi[7:0]});
                dtdr_pkg::HDR_RAMWR: word_c = dtdr_pkg::rev9(dtdr_pkg::CMD_RAMWR);
                default:             word_c = dtdr_pkg::rev9(dtdr_pkg::DATA_FLAG);
            endcase
        end else begin
            case (r_phase)
                2'd0:    word_c = {1'b0, r_p[5:3], 1'b0, r_p[2:0], 1'b1};
                2'd1:    word_c = {1'b0, q_pix[2:0], 2'b00, r_p[7:6], 1'b1};
                default: word_c = {2'b00, q_pix[7:6], 1'b0, q_pix[5:3], 1'b1};
            endcase
        end
    end

    assign last_c = !r_none && !r_in_hdr && (r_phase == 2'd2) &&
                    (r_pcol == PCW'(dtdr_pkg::PAIRS_PER_ROW - 1)) &&
                    (r_prow == PRW'(dtdr_pkg::TILE_HEIGHT - 1));
    assign load   = (r_state == S_EMIT) && (!r_ov || !i_out_stall);
    assign o_q_pop = (r_state == S_IDLE) && i_q_valid;

    // frame store port control
    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_clr_addr;
        mem_wd = r_fill;
        if (r_state == S_CLEAR) begin
            mem_we = 1'b1;
        end else if (o_q_pop && i_q_item.kind == dtdr_pkg::KIND_WRITE && wr_ok) begin
            mem_we = 1'b1;
            mem_wa = AW'(32'(i_q_item.pos_y) * dtdr_pkg::SCREEN_WIDTH + 32'(i_q_item.pos_x));
            mem_wd = i_q_item.color;
        end
        mem_ra = (r_state == S_RDP) ? addr_p : addr_q;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rdata <= r_mem[mem_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_fill     <= 8'd0;
            r_dirty    <= '0;
            r_scan     <= '0;
            r_scan_tx  <= '0;
            r_scan_ty  <= '0;
            r_probe    <= '0;
            r_probe_tx <= '0;
            r_probe_ty <= '0;
            r_probe_n  <= '0;
            r_act_tx   <= '0;
            r_act_ty   <= '0;
            r_sending  <= 1'b0;
            r_in_hdr   <= 1'b1;
            r_hdr      <= '0;
            r_phase    <= '0;
            r_pcol     <= '0;
            r_prow     <= '0;
            r_none     <= 1'b0;
            r_ov       <= 1'b0;
        end else begin
            // a new beat loaded in emit keeps the output valid
            if (r_ov && !i_out_stall && !load) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    if (r_clr_addr == AW'(dtdr_pkg::PIXELS - 1)) begin
                        r_clr_addr <= '0;
                        r_state    <= S_IDLE;
                    end else begin
                        r_clr_addr <= r_clr_addr + 1'b1;
                    end
                end
                S_IDLE: begin
                    if (i_q_valid) begin
                        case (i_q_item.kind)
                            dtdr_pkg::KIND_WRITE: begin
                                if (wr_ok) begin
                                    r_dirty[wr_tile] <= 1'b1;
                                end
                            end
                            dtdr_pkg::KIND_CLEAR: begin
                                r_fill  <= i_q_item.color;
                                r_dirty <= '1;
                                r_state <= S_CLEAR;
                            end
                            dtdr_pkg::KIND_FETCH: begin
                                if (!r_sending) begin
                                    r_probe    <= r_scan;
                                    r_probe_tx <= r_scan_tx;
                                    r_probe_ty <= r_scan_ty;
                                    r_probe_n  <= '0;
                                    r_state    <= S_SCAN;
                                end else if (r_in_hdr) begin
                                    r_state <= S_EMIT;
                                end else begin
                                    r_state <= S_RDP;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_SCAN: begin
                    if (r_dirty[r_probe]) begin
                        r_dirty[r_probe] <= 1'b0;
                        r_act_tx  <= r_probe_tx;
                        r_act_ty  <= r_probe_ty;
                        r_scan    <= nx_idx;
                        r_scan_tx <= nx_tx;
                        r_scan_ty <= nx_ty;
                        r_sending <= 1'b1;
                        r_in_hdr  <= 1'b1;
                        r_hdr     <= '0;
                        r_state   <= S_EMIT;
                    end else if (r_probe_n == IW'(dtdr_pkg::TILE_COUNT - 1)) begin
                        r_none  <= 1'b1;
                        r_state <= S_EMIT;
                    end else begin
                        r_probe    <= nx_idx;
                        r_probe_tx <= nx_tx;
                        r_probe_ty <= nx_ty;
                        r_probe_n  <= r_probe_n + 1'b1;
                    end
                end
                S_RDP: begin
                    r_state <= S_RDQ;
                end
                S_RDQ: begin
                    r_p     <= p_ok ? r_rdata : 8'd0;
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (load) begin
                        r_ov    <= 1'b1;
                        r_word  <= word_c;
                        r_vres  <= !r_none;
                        r_last  <= last_c;
                        r_none  <= 1'b0;
                        r_state <= S_IDLE;
                        if (!r_none) begin
                            if (r_in_hdr) begin
                                if (r_hdr == dtdr_pkg::HDR_RAMWR) begin
                                    r_in_hdr <= 1'b0;
                                    r_phase  <= '0;
                                    r_pcol   <= '0;
                                    r_prow   <= '0;
                                end else begin
                                    r_hdr <= r_hdr + 1'b1;
                                end
                            end else if (last_c) begin
                                r_sending <= 1'b0;
                                r_in_hdr  <= 1'b1;
                                r_hdr     <= '0;
                            end else if (r_phase != 2'd2) begin
                                r_phase <= r_phase + 1'b1;
                            end else begin
                                r_phase <= '0;
                                if (r_pcol == PCW'(dtdr_pkg::PAIRS_PER_ROW - 1)) begin
                                    r_pcol <= '0;
                                    r_prow <= r_prow + 1'b1;
                                end else begin
                                    r_pcol <= r_pcol + 1'b1;
                                end
                            end
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `DTDR_ASSERT(a_load_from_emit, $rose(r_ov) |-> $past(r_state == S_EMIT), "beat loaded outside emit")
    `DTDR_ASSERT(a_scan_bound, (r_state == S_SCAN) |-> (r_probe_n <= IW'(dtdr_pkg::TILE_COUNT - 1)), "scan ran past tile count")
    `DTDR_ASSERT(a_last_ends, (load && last_c) |=> !r_sending, "transfer still open after last beat")
    `DTDR_ASSERT_RST(a_reset_sweep, !i_rst_n |=> (!r_ov && r_state == S_CLEAR), "reset did not start sweep")

endmodule

// File: sv/dirty_tile_display_refresh.sv
// ---------------------------------------------------------------------------
// dirty_tile_display_refresh
// Frame store with per-tile dirty flags, streaming dirty tiles to a panel.
// ---------------------------------------------------------------------------
// Order: a write is stored when the work side pops it; a header word goes from
//   idle to emit, a pixel word through two store reads first; a tile start first probes the dirty flags (max 80).
// Rate: one write per cycle while the work side is idle; each fetch yields one
//   word, and no new item is taken until it is loaded; a clear occupies the work side for one store sweep.
// Reset: synchronous; after reset the frame store is zeroed by the same
//   store sweep, during which items queue and then stall.
`timescale 1ns / 1ps

module dirty_tile_display_refresh (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // APB configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // item beats
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_kind,
    input  logic [7:0]  i_pos_x,
    input  logic [7:0]  i_pos_y,
    input  logic [7:0]  i_color,
    // result beats
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [8:0]  o_word,
    output logic        o_valid_res,
    output logic        o_last
);

    logic [7:0]      r_col_offset;
    logic [7:0]      r_row_offset;
    dtdr_pkg::t_item in_item;
    dtdr_pkg::t_item q_item;
    logic            q_valid;
    logic            q_pop;

    // Register map: column offset at 0x0, row offset at 0x4.
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_offset <= 8'd0;
            r_row_offset <= 8'd0;
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == dtdr_pkg::REG_COL_OFFSET) begin
                r_col_offset <= pwdata[7:0];
            end else begin
                r_row_offset <= pwdata[7:0];
            end
        end
    end

    assign prdata = (paddr[2] == dtdr_pkg::REG_COL_OFFSET) ? {24'd0, r_col_offset}
                                                            : {24'd0, r_row_offset};

    assign in_item.kind  = i_kind;
    assign in_item.pos_x = i_pos_x;
    assign in_item.pos_y = i_pos_y;
    assign in_item.color = i_color;

    // Front: takes beats into a two-deep queue so the work side can stall
    // (store sweep, tile scan, output backpressure) while up to two items wait.
    dtdr_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_item     (in_item),
        .o_q_valid  (q_valid),
        .o_q_item   (q_item),
        .i_q_pop    (q_pop)
    );

    // Back: one item at a time; owns the frame store, dirty flags and the
    // registered output beat.
    dtdr_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .i_q_item     (q_item),
        .o_q_pop      (q_pop),
        .i_col_offset (r_col_offset),
        .i_row_offset (r_row_offset),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_word       (o_word),
        .o_valid_res  (o_valid_res),
        .o_last       (o_last)
    );

endmodule
